@@ rtl/core/qrs_pkg.sv @@
// Shared widths, mode codes and stage sideband types of the quadratic root solver.
package qrs_pkg;

    localparam int CW    = 32;           // coefficient and root width
    localparam int FB    = 16;           // fraction bits
    localparam int TOLW  = 16;           // tolerance register width
    localparam int DW    = 2 * CW + 4;   // signed discriminant
    localparam int SQN   = CW + 1;       // square root result bits
    localparam int RADW  = 2 * SQN;      // radicand bits
    localparam int SRW   = SQN + 3;      // square root remainder
    localparam int NUMW  = CW + 3;       // signed numerator
    localparam int NMW   = CW + 2;       // numerator magnitude
    localparam int DENW  = CW + 1;       // denominator magnitude and signed width
    localparam int DVW   = NMW + FB;     // dividend and quotient bits
    localparam int DRW   = DENW + 1;     // divider remainder
    localparam int MODEW = 3;

    localparam logic [MODEW-1:0] M_NONE = 3'd0;
    localparam logic [MODEW-1:0] M_INF  = 3'd1;
    localparam logic [MODEW-1:0] M_LIN  = 3'd2;
    localparam logic [MODEW-1:0] M_ONE  = 3'd3;
    localparam logic [MODEW-1:0] M_TWO  = 3'd4;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    localparam logic [0:0] REG_TOL = 1'b0;

    typedef struct packed {
        logic [MODEW-1:0] mode;
        logic [CW-1:0]    a;
        logic [CW-1:0]    b;
        logic [CW-1:0]    c;
    } t_sq_side;

    typedef struct packed {
        logic [MODEW-1:0] mode;
        logic             neg_a;
        logic             neg_b;
    } t_dv_side;

    // |x| < tol, or x exactly zero
    function automatic logic is_zero(input logic [CW-1:0] x, input logic [TOLW-1:0] tol);
        logic [CW-1:0] m;
        m = x[CW-1] ? (~x + 1'b1) : x;
        return (x == '0) || (m < CW'(tol));
    endfunction

endpackage

@@ rtl/core/quadratic_root_solver_top.sv @@
// Top level of the pipelined fixed-point quadratic root solver.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+----------------------------------
//  s_      | in  | s_tvalid / s_tready          | s_tdata: a, b, c (Q16.16, 32 b each)
//  m_      | out | m_tvalid / m_tready          | m_tdata: count, root1, root2, sat
//  apb     | in  | psel / penable / pwrite      | reg 0 at 0x0: zero tolerance
//
// One item per cycle while the output is not stalled. The pipe, in order, for Q16.16
// coefficients: three front stages (tolerance tests, the two 32x32 products, the
// discriminant), one stage per root bit of the square root, a numerator stage,
// one stage per quotient bit of the two parallel restoring dividers, and the
// output register. Reset (synchronous, active low) empties every stage and sets
// the tolerance to 1. A stall on m_tready freezes the whole pipe in place.
module quadratic_root_solver_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [31:0] coef_square, [63:32] coef_linear, [95:64] coef_constant
    input  logic [3*qrs_pkg::CW-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [1:0] root_count, [33:2] root_first, [65:34] root_second, [66] saturated, rest 0
    output logic [71:0]              m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import qrs_pkg::*;

    logic en;

    // configuration
    logic [TOLW-1:0] r_tol;

    // stage 1: registered coefficients and zero flags
    logic          r1_v;
    logic [CW-1:0] r1_a, r1_b, r1_c;
    logic          r1_za, r1_zb, r1_zc;

    // stage 2: products
    logic            r2_v;
    logic [CW-1:0]   r2_a, r2_b, r2_c;
    logic            r2_za, r2_zb, r2_zc;
    logic [2*CW-1:0] r2_p;
    logic [2*CW-1:0] r2_q;
    logic [CW-1:0]   n2_mb;

    // discriminant
    logic [DW-1:0]    n3_d;
    logic             n3_near;
    logic [MODEW-1:0] n3_mode;

    // square root pipe
    logic             r_sq_v    [0:SQN];
    t_sq_side         r_sq_side [0:SQN];
    logic [RADW-1:0]  r_sq_rad  [0:SQN];
    logic [SRW-1:0]   r_sq_rem  [0:SQN];
    logic [SQN-1:0]   r_sq_root [0:SQN];
    logic [RADW-1:0]  n_sq_rad  [0:SQN-1];
    logic [SRW-1:0]   n_sq_rem  [0:SQN-1];
    logic [SQN-1:0]   n_sq_root [0:SQN-1];

    // numerator stage
    t_sq_side         n4_s;
    logic [NUMW-1:0]  n4_nb, n4_sq, n4_numa, n4_numb;
    logic [DENW-1:0]  n4_den;
    logic [NMW-1:0]   n4_ua, n4_ub;
    logic [DENW-1:0]  n4_ud;

    // divider pipe
    logic             r_dv_v    [0:DVW];
    t_dv_side         r_dv_side [0:DVW];
    logic [DENW-1:0]  r_dv_den  [0:DVW];
    logic [DVW-1:0]   r_dva_num [0:DVW];
    logic [DRW-1:0]   r_dva_rem [0:DVW];
    logic [DVW-1:0]   r_dva_q   [0:DVW];
    logic [DVW-1:0]   r_dvb_num [0:DVW];
    logic [DRW-1:0]   r_dvb_rem [0:DVW];
    logic [DVW-1:0]   r_dvb_q   [0:DVW];
    logic [DRW-1:0]   n_dva_rem [0:DVW-1];
    logic [DVW-1:0]   n_dva_q   [0:DVW-1];
    logic [DRW-1:0]   n_dvb_rem [0:DVW-1];
    logic [DVW-1:0]   n_dvb_q   [0:DVW-1];

    // output
    logic            r_out_valid;
    logic [71:0]     r_out_data;
    logic [CW-1:0]   n_ra, n_rb;
    logic            n_sa, n_sb, n_sat;
    logic [1:0]      n_cnt;
    logic [CW-1:0]   n_r1, n_r2;

    assign en       = !r_out_valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign pready   = 1'b1;
    assign prdata   = 32'(r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOLW'(1);
        end else if (psel && penable && pwrite && (paddr[1:0] == {REG_TOL, 1'b0})) begin
            r_tol <= pwdata[TOLW-1:0];
        end
    end

    // ---------------- front stages ----------------
    assign n2_mb = r1_b[CW-1] ? (~r1_b + 1'b1) : r1_b;

    always_comb begin
        n3_d    = {4'b0, r2_p} - {{2{r2_q[2*CW-1]}}, r2_q, 2'b00};
        n3_near = (n3_d == '0) || (n3_d < DW'({r_tol, {FB{1'b0}}}));
        if (r2_za) begin
            if (r2_zb) begin
                n3_mode = r2_zc ? M_INF : M_NONE;
            end else begin
                n3_mode = M_LIN;
            end
        end else if (n3_d[DW-1]) begin
            n3_mode = M_NONE;
        end else if (n3_near) begin
            n3_mode = M_ONE;
        end else begin
            n3_mode = M_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r1_v      <= s_tvalid;
            r2_v      <= r1_v;
            r_sq_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a  <= s_tdata[CW-1:0];
            r1_b  <= s_tdata[2*CW-1:CW];
            r1_c  <= s_tdata[3*CW-1:2*CW];
            r1_za <= is_zero(s_tdata[CW-1:0], r_tol);
            r1_zb <= is_zero(s_tdata[2*CW-1:CW], r_tol);
            r1_zc <= is_zero(s_tdata[3*CW-1:2*CW], r_tol);

            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_za <= r1_za;
            r2_zb <= r1_zb;
            r2_zc <= r1_zc;
            r2_p  <= n2_mb * n2_mb;
            r2_q  <= (2*CW)'($signed(r1_a) * $signed(r1_c));

            r_sq_side[0] <= '{mode: n3_mode, a: r2_a, b: r2_b, c: r2_c};
            r_sq_rad[0]  <= n3_d[RADW-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    always_comb begin
        logic [SRW-1:0] trem;
        logic [SRW-1:0] trial;
        for (int k = 0; k < SQN; k++) begin
            trem  = {r_sq_rem[k][SRW-3:0], r_sq_rad[k][RADW-1 -: 2]};
            trial = SRW'({r_sq_root[k], 2'b01});
            n_sq_rad[k] = {r_sq_rad[k][RADW-3:0], 2'b00};
            if (trem >= trial) begin
                n_sq_rem[k]  = trem - trial;
                n_sq_root[k] = {r_sq_root[k][SQN-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = trem;
                n_sq_root[k] = {r_sq_root[k][SQN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQN; k++) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < SQN; k++) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_rad[k+1]  <= n_sq_rad[k];
                r_sq_rem[k+1]  <= n_sq_rem[k];
                r_sq_root[k+1] <= n_sq_root[k];
            end
        end
    end

    // ---------------- numerators and divisor ----------------
    always_comb begin
        n4_s    = r_sq_side[SQN];
        n4_nb   = -NUMW'($signed(n4_s.b));
        n4_sq   = NUMW'(r_sq_root[SQN]);
        n4_numa = '0;
        n4_numb = '0;
        n4_den  = DENW'({n4_s.a, 1'b0});
        unique case (n4_s.mode)
            M_LIN: begin
                n4_numa = -NUMW'($signed(n4_s.c));
                n4_den  = DENW'($signed(n4_s.b));
            end
            M_ONE: begin
                n4_numa = n4_nb;
            end
            M_TWO: begin
                n4_numa = n4_nb + n4_sq;
                n4_numb = n4_nb - n4_sq;
            end
            default: begin
                n4_numa = '0;
            end
        endcase
        n4_ua = n4_numa[NUMW-1] ? NMW'(-n4_numa) : NMW'(n4_numa);
        n4_ub = n4_numb[NUMW-1] ? NMW'(-n4_numb) : NMW'(n4_numb);
        n4_ud = n4_den[DENW-1] ? (~n4_den + 1'b1) : n4_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[SQN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= '{mode:  n4_s.mode,
                              neg_a: n4_numa[NUMW-1] ^ n4_den[DENW-1],
                              neg_b: n4_numb[NUMW-1] ^ n4_den[DENW-1]};
            r_dv_den[0]  <= n4_ud;
            r_dva_num[0] <= {n4_ua, {FB{1'b0}}};
            r_dvb_num[0] <= {n4_ub, {FB{1'b0}}};
            r_dva_rem[0] <= '0;
            r_dvb_rem[0] <= '0;
            r_dva_q[0]   <= '0;
            r_dvb_q[0]   <= '0;
        end
    end

    // ---------------- two restoring dividers, one quotient bit per stage ----
    always_comb begin
        logic [DRW-1:0] ta;
        logic [DRW-1:0] tb;
        logic [DRW-1:0] dd;
        for (int k = 0; k < DVW; k++) begin
            dd = {1'b0, r_dv_den[k]};
            ta = {r_dva_rem[k][DRW-2:0], r_dva_num[k][DVW-1]};
            tb = {r_dvb_rem[k][DRW-2:0], r_dvb_num[k][DVW-1]};
            if (ta >= dd) begin
                n_dva_rem[k] = ta - dd;
                n_dva_q[k]   = {r_dva_q[k][DVW-2:0], 1'b1};
            end else begin
                n_dva_rem[k] = ta;
                n_dva_q[k]   = {r_dva_q[k][DVW-2:0], 1'b0};
            end
            if (tb >= dd) begin
                n_dvb_rem[k] = tb - dd;
                n_dvb_q[k]   = {r_dvb_q[k][DVW-2:0], 1'b1};
            end else begin
                n_dvb_rem[k] = tb;
                n_dvb_q[k]   = {r_dvb_q[k][DVW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DVW; k++) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < DVW; k++) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_den[k+1]  <= r_dv_den[k];
                r_dva_num[k+1] <= {r_dva_num[k][DVW-2:0], 1'b0};
                r_dvb_num[k+1] <= {r_dvb_num[k][DVW-2:0], 1'b0};
                r_dva_rem[k+1] <= n_dva_rem[k];
                r_dvb_rem[k+1] <= n_dvb_rem[k];
                r_dva_q[k+1]   <= n_dva_q[k];
                r_dvb_q[k+1]   <= n_dvb_q[k];
            end
        end
    end

    // ---------------- sign, saturation and result assembly ----------------
    function automatic logic [CW:0] fix_sign(input logic [DVW-1:0] q, input logic neg);
        logic [DVW-CW:0] hi;
        logic            over;
        logic [CW-1:0]   r;
        hi = q[DVW-1:CW-1];
        if (neg) begin
            over = (hi > (DVW-CW+1)'(1)) || ((hi == (DVW-CW+1)'(1)) && (q[CW-2:0] != '0));
            r    = over ? {1'b1, {(CW-1){1'b0}}} : (~q[CW-1:0] + 1'b1);
        end else begin
            over = (hi != '0);
            r    = over ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
        end
        return {over, r};
    endfunction

    always_comb begin
        {n_sa, n_ra} = fix_sign(r_dva_q[DVW], r_dv_side[DVW].neg_a);
        {n_sb, n_rb} = fix_sign(r_dvb_q[DVW], r_dv_side[DVW].neg_b);
        n_r1  = '0;
        n_r2  = '0;
        n_sat = 1'b0;
        unique case (r_dv_side[DVW].mode)
            M_INF: begin
                n_cnt = CNT_INF;
            end
            M_LIN, M_ONE: begin
                n_cnt = CNT_ONE;
                n_r1  = n_ra;
                n_sat = n_sa;
            end
            M_TWO: begin
                n_cnt = CNT_TWO;
                n_r1  = n_ra;
                n_r2  = n_rb;
                n_sat = n_sa || n_sb;
            end
            default: begin
                n_cnt = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_v[DVW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {5'b0, n_sat, n_r2, n_r1, n_cnt};
        end
    end

    // ---------------- checks ----------------
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[1:0] == CNT_NONE || m_tdata[1:0] == CNT_INF)) |->
        (m_tdata[66:2] == '0))
        else $error("roots or saturation reported without a root");

    a_second_only_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1:0] != CNT_TWO) |-> (m_tdata[65:34] == '0))
        else $error("second root set without two roots");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the quadratic root solver: directed and random equations.
`timescale 1ns / 100ps

module testbench;
    import qrs_pkg::*;

    localparam longint ROOT_MAX = 64'sd2147483647;
    localparam longint ROOT_MIN = -64'sd2147483648;
    localparam int     N_RANDOM = 1830;
    localparam int     LIMIT    = 400000;

    typedef struct {
        logic [1:0]  count;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        sat;
    } t_roots;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        known;     // expected roots typed in below
        t_roots      roots;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quadratic_root_solver_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tolerance mirror and the queue of roots still owed by the block
    logic [15:0] tol_now = 16'd1;
    t_roots      roots_due[$];
    int          n_err = 0;
    int          cycles = 0;
    bit          rx_on = 1'b0;

    // tolerance settings of the random phases, extremes included
    logic [15:0] tol_steps[6] = '{16'd0, 16'd1, 16'hFFFF, 16'd300, 16'd0, 16'h0800};

    // |x| below epsilon, or exactly zero
    function automatic bit coef_is_zero(longint x);
        longint m;
        m = (x < 0) ? -x : x;
        return (x == 0) || (m < longint'(tol_now));
    endfunction

    // fixed-point num/den toward zero, clipped to Q16.16
    function automatic longint fx_quot(longint num, longint den, ref bit sat);
        logic [127:0] q;
        logic [127:0] un;
        logic [127:0] ud;
        bit neg;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        if (ud == 0) begin
            if (num == 0) return 0;
            sat = 1'b1;
            return (num > 0) ? ROOT_MAX : ROOT_MIN;
        end
        q = (un << 16) / ud;
        if (neg) begin
            if (q > 128'(64'd2147483648)) begin
                sat = 1'b1;
                return ROOT_MIN;
            end
            return -longint'(q);
        end
        if (q > 128'(64'd2147483647)) begin
            sat = 1'b1;
            return ROOT_MAX;
        end
        return longint'(q);
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int k = 40; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_roots solve_equation(logic [31:0] ra, logic [31:0] rb,
                                              logic [31:0] rc);
        t_roots res;
        longint a, b, c, s, x1, x2;
        logic signed [127:0] disc;
        bit sat;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        c = longint'($signed(rc));
        sat = 1'b0;
        x1 = 0;
        x2 = 0;
        if (coef_is_zero(a)) begin
            if (coef_is_zero(b)) res.count = coef_is_zero(c) ? CNT_INF : CNT_NONE;
            else begin
                res.count = CNT_ONE;
                x1 = fx_quot(-c, b, sat);
            end
        end else begin
            disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
            if (disc < 0) res.count = CNT_NONE;
            else if (disc == 0 || disc < (128'(tol_now) << 16)) begin
                res.count = CNT_ONE;
                x1 = fx_quot(-b, 2 * a, sat);
            end else begin
                s = longint'(isqrt(disc));
                res.count = CNT_TWO;
                x1 = fx_quot(-b + s, 2 * a, sat);
                x2 = fx_quot(-b - s, 2 * a, sat);
            end
        end
        res.r1 = x1[31:0];
        res.r2 = x2[31:0];
        res.sat = sat;
        return res;
    endfunction

    // APB write: setup then access, driven on falling edges
    task automatic write_tolerance(logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {REG_TOL, 1'b0} << 1; pwdata <= {16'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tol_now = val;
    endtask

    // drain: nothing owed, then wait out the pipe latency
    task automatic wait_idle();
        while (roots_due.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // send one equation; sender gaps come in random bursts
    int burst_left = 0;
    task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 bit known, t_roots want);
        if (burst_left == 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) * ($urandom_range(0, 2) == 0)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        roots_due.push_back(known ? want : solve_equation(a, b, c));
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                          : 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 8;
        endcase
    endfunction

    // receiver: stall pattern switches between bursty, sparse and none
    always @(negedge i_clk) begin
        if (!rx_on) m_tready <= 1'b0;
        else case ((cycles / 500) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (cycles % 7) < 3;
        endcase
    end

    // compare every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_roots want;
        cycles <= cycles + 1;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (roots_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                n_err++;
            end else begin
                want = roots_due.pop_front();
                if (m_tdata[1:0] !== want.count || m_tdata[33:2] !== want.r1 ||
                    m_tdata[65:34] !== want.r2 || m_tdata[66] !== want.sat ||
                    m_tdata[71:67] !== 5'd0) begin
                    $display("%0t: mismatch expected cnt=%0d r1=%h r2=%h sat=%b",
                             $time, want.count, want.r1, want.r2, want.sat);
                    $display("%0t:          actual   cnt=%0d r1=%h r2=%h sat=%b",
                             $time, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
                             m_tdata[66]);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    t_row rows[$];
    t_roots none_r, inf_r, z;

    initial begin
        none_r = '{CNT_NONE, 32'd0, 32'd0, 1'b0};
        inf_r  = '{CNT_INF, 32'd0, 32'd0, 1'b0};
        z      = '{CNT_NONE, 32'd0, 32'd0, 1'b0};
        // all zero: infinitely many roots
        rows.push_back('{32'd0, 32'd0, 32'd0, 1'b1, inf_r});
        // a and b zero, c not: no root
        rows.push_back('{32'd0, 32'd0, 32'h0001_0000, 1'b1, none_r});
        // linear 2x - 4 = 0 gives 2
        rows.push_back('{32'd0, 32'h0002_0000, 32'hFFFC_0000, 1'b1,
                         '{CNT_ONE, 32'h0002_0000, 32'd0, 1'b0}});
        // linear with saturation both ways
        rows.push_back('{32'd0, 32'd1, 32'h8000_0000, 1'b1,
                         '{CNT_ONE, 32'h7FFF_FFFF, 32'd0, 1'b1}});
        rows.push_back('{32'd0, 32'd1, 32'h7FFF_FFFF, 1'b1,
                         '{CNT_ONE, 32'h8000_0000, 32'd0, 1'b1}});
        // x^2 + 1: negative discriminant
        rows.push_back('{32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1, none_r});
        // x^2 - 2x + 1: double root 1
        rows.push_back('{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b1,
                         '{CNT_ONE, 32'h0001_0000, 32'd0, 1'b0}});
        // x^2 - 1: roots 1 and -1
        rows.push_back('{32'h0001_0000, 32'd0, 32'hFFFF_0000, 1'b1,
                         '{CNT_TWO, 32'h0001_0000, 32'hFFFF_0000, 1'b0}});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, z});
        rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, z});
        rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, z});
        rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, z});
        rows.push_back('{32'd1, 32'h7FFF_FFFF, 32'd0, 1'b0, z});
        rows.push_back('{32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, z});
        rows.push_back('{32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, z});
        rows.push_back('{32'd1, 32'd1, 32'd0, 1'b0, z});
        rows.push_back('{32'h0003_0000, 32'h0005_0000, 32'hFFF9_0000, 1'b0, z});
        rows.push_back('{32'hFFFD_8000, 32'h0001_0000, 32'h0000_4000, 1'b0, z});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_on = 1'b1;

        // reset tolerance (1): directed table
        foreach (rows[k]) send_equation(rows[k].a, rows[k].b, rows[k].c,
                                        rows[k].known, rows[k].roots);
        end_burst();
        wait_idle();

        // random phases over several tolerance settings
        foreach (tol_steps[p]) begin
            write_tolerance(tol_steps[p]);
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                logic [31:0] ra, rb, rc;
                ra = rand_coef();
                rb = rand_coef();
                rc = rand_coef();
                if ($urandom_range(0, 9) == 0) ra = $urandom_range(0, 1) ?
                    32'($urandom_range(0, 65535)) : -32'($urandom_range(0, 65535));
                if ($urandom_range(0, 19) == 0) rb = 32'($urandom_range(0, 65535));
                send_equation(ra, rb, rc, 1'b0, z);
            end
            end_burst();
            wait_idle();
        end

        if (n_err == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
